// ----- hw/rtl/adc_millivolt_with_vref_calibration_unit_assert.svh -----
// ----------------------------------------------------------------------------
// assertion macros for the adc millivolt unit
// ----------------------------------------------------------------------------
`ifndef ADC_MILLIVOLT_WITH_VREF_CALIBRATION_UNIT_ASSERT_SVH
`define ADC_MILLIVOLT_WITH_VREF_CALIBRATION_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define ADCMV_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("adcmv assertion failed");

// next-cycle implication, disabled during reset
`define ADCMV_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("adcmv assertion failed");

`endif

// ----- hw/rtl/adcmv_pkg.sv -----
// ----------------------------------------------------------------------------
// adcmv_pkg
// shared types and constants of the adc millivolt unit
// ----------------------------------------------------------------------------
`default_nettype none

package adcmv_pkg;

  // digits handled per serial pass (multiplier and divider)
  localparam int unsigned DIGITS     = 16;
  localparam int unsigned DIGIT_CNTW = 4;

  // reference voltage times 12-bit full scale: 1210 * 4095
  localparam logic [31:0] VREF_PRODUCT = 32'd4954950;
  localparam logic [15:0] FS16         = 16'd65535;
  localparam logic [15:0] FS12         = 16'd4095;
  localparam logic [15:0] MAX16        = 16'd65535;

  // input codes
  localparam logic OP_REF  = 1'b0;
  localparam logic OP_MEAS = 1'b1;
  localparam logic KIND_16 = 1'b0;
  localparam logic KIND_12 = 1'b1;

  typedef enum logic [2:0] {
    STATUS_CONVERTED = 3'd0,
    STATUS_ABSORBED  = 3'd1,
    STATUS_CAL_DONE  = 3'd2,
    STATUS_NOT_CAL   = 3'd3,
    STATUS_IGNORED   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_MEAS_START,
    S_DIV_MEAS,
    S_DIV_AVG,
    S_DIV_SUPPLY,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// ----- hw/rtl/adcmv_divider.sv -----
// ----------------------------------------------------------------------------
// adcmv_divider
// bit-serial restoring divider, 32 by 16 bits, quotient saturated to 16 bits
// ----------------------------------------------------------------------------
`default_nettype none

module adcmv_divider (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire adcmv_pkg::div_req_t req,
  output adcmv_pkg::div_rsp_t      rsp
);

  logic                                busy;
  logic [adcmv_pkg::DIGIT_CNTW-1:0]    cnt;
  logic [15:0]                         rem;
  logic [15:0]                         dlo;
  logic [15:0]                         dvs;
  logic [15:0]                         quo;
  logic                                done;
  logic [16:0]                         trial;
  logic                                qbit;
  logic [16:0]                         diff;

  // one quotient bit per cycle
  always_comb begin
    trial = {rem, dlo[15]};
    diff  = trial - {1'b0, dvs};
    qbit  = (trial >= {1'b0, dvs});
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        cnt <= '0;
        // high half not below divisor: quotient would not fit, saturate
        if (req.dividend[31:16] >= req.divisor) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == adcmv_pkg::DIGIT_CNTW'(adcmv_pkg::DIGITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      rem <= req.dividend[31:16];
      dlo <= req.dividend[15:0];
      dvs <= req.divisor;
      quo <= adcmv_pkg::MAX16;
    end else if (busy) begin
      rem <= qbit ? diff[15:0] : trial[15:0];
      dlo <= {dlo[14:0], 1'b0};
      quo <= {quo[14:0], qbit};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

`default_nettype wire

// ----- hw/rtl/adc_millivolt_with_vref_calibration_unit.sv -----
// ----------------------------------------------------------------------------
// adc_millivolt_with_vref_calibration_unit
// adc sample to millivolt scaling with internal-reference supply calibration
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries op, raw_sample, converter_kind.
// Output channel (out_valid/out_ready) carries millivolts and status, one
// result beat per input beat.
// Reference samples are summed; the CAL_SAMPLES-th one averages the sum and
// sets the supply as 4954950 / average through the serial divider.
// Measurements run a serial shift-add multiply by the supply, then a
// serial divide by the full scale. A completing reference runs two divides,
// the average and then the supply; any other item goes straight to the
// output register. A divide whose quotient would not fit skips the serial
// pass and saturates. The next beat can be accepted in the cycle after the
// result register loads. The serial multiplier and the one shared bit-serial
// divider do this work; one item is in work at a time.
// in_ready is high only while no item is in work. A finished result waits in
// the output register while the next item is accepted; if the receiver still
// holds the earlier result, the new one waits until it is taken.
// Reset clears calibration state and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module adc_millivolt_with_vref_calibration_unit #(
  parameter int unsigned CAL_SAMPLES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        op,
  input  wire logic [15:0] raw_sample,
  input  wire logic        converter_kind,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      millivolts,
  output logic [2:0]       status
);

  localparam int unsigned CNTW = $clog2(CAL_SAMPLES + 1);

  adcmv_pkg::state_t                 state;
  adcmv_pkg::state_t                 state_next;
  adcmv_pkg::div_req_t               div_req;
  adcmv_pkg::div_rsp_t               div_rsp;

  logic [15:0]                       ref_sum;
  logic [CNTW-1:0]                   ref_count;
  logic [15:0]                       supply_mv;
  logic                              is_calibrated;

  logic [15:0]                       mul_hi;
  logic [15:0]                       mul_lo;
  logic [adcmv_pkg::DIGIT_CNTW-1:0]  mul_cnt;
  logic                              kind;
  logic [16:0]                       mul_sum;

  logic [15:0]                       res_mv;
  adcmv_pkg::status_t                res_status;

  logic                              in_fire;
  logic                              out_load;
  logic                              last_ref;
  logic [16:0]                       sum_ext;
  logic [15:0]                       sum_sat;

  assign in_ready = (state == adcmv_pkg::S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_load = (state == adcmv_pkg::S_FINISH) && (!out_valid || out_ready);
  assign last_ref = (ref_count == CNTW'(CAL_SAMPLES - 1));

  // saturating reference sum and one shift-add step
  always_comb begin
    sum_ext = {1'b0, ref_sum} + {1'b0, raw_sample};
    sum_sat = sum_ext[16] ? adcmv_pkg::MAX16 : sum_ext[15:0];
    mul_sum = {1'b0, mul_hi} + (mul_lo[0] ? {1'b0, supply_mv} : 17'd0);
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= adcmv_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and divider requests
  always_comb begin
    state_next       = state;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    unique case (state)
      adcmv_pkg::S_IDLE: begin
        if (in_valid) begin
          if (op == adcmv_pkg::OP_REF) begin
            if (!is_calibrated && last_ref) begin
              div_req.start    = 1'b1;
              div_req.dividend = {16'd0, sum_sat};
              div_req.divisor  = 16'(CAL_SAMPLES);
              state_next       = adcmv_pkg::S_DIV_AVG;
            end else begin
              state_next = adcmv_pkg::S_FINISH;
            end
          end else begin
            state_next = is_calibrated ? adcmv_pkg::S_MUL : adcmv_pkg::S_FINISH;
          end
        end
      end
      adcmv_pkg::S_MUL: begin
        if (mul_cnt == adcmv_pkg::DIGIT_CNTW'(adcmv_pkg::DIGITS - 1)) begin
          state_next = adcmv_pkg::S_MEAS_START;
        end
      end
      adcmv_pkg::S_MEAS_START: begin
        div_req.start    = 1'b1;
        div_req.dividend = {mul_hi, mul_lo};
        div_req.divisor  = (kind == adcmv_pkg::KIND_12) ? adcmv_pkg::FS12 : adcmv_pkg::FS16;
        state_next       = adcmv_pkg::S_DIV_MEAS;
      end
      adcmv_pkg::S_DIV_MEAS: begin
        if (div_rsp.done) begin
          state_next = adcmv_pkg::S_FINISH;
        end
      end
      adcmv_pkg::S_DIV_AVG: begin
        // average ready, divide the reference product by it
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = adcmv_pkg::VREF_PRODUCT;
          div_req.divisor  = div_rsp.quotient;
          state_next       = adcmv_pkg::S_DIV_SUPPLY;
        end
      end
      adcmv_pkg::S_DIV_SUPPLY: begin
        if (div_rsp.done) begin
          state_next = adcmv_pkg::S_FINISH;
        end
      end
      adcmv_pkg::S_FINISH: begin
        if (!out_valid || out_ready) begin
          state_next = adcmv_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = adcmv_pkg::S_IDLE;
      end
    endcase
  end

  adcmv_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // calibration state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_sum       <= '0;
      ref_count     <= '0;
      supply_mv     <= '0;
      is_calibrated <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (in_fire && op == adcmv_pkg::OP_REF && !is_calibrated) begin
        ref_sum   <= sum_sat;
        ref_count <= ref_count + 1'b1;
      end
      if (state == adcmv_pkg::S_DIV_SUPPLY && div_rsp.done) begin
        supply_mv     <= div_rsp.quotient;
        is_calibrated <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // serial multiplier and result registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_mv  <= '0;
      mul_hi  <= '0;
      mul_lo  <= raw_sample;
      mul_cnt <= '0;
      kind    <= converter_kind;
      if (op == adcmv_pkg::OP_REF) begin
        res_status <= is_calibrated ? adcmv_pkg::STATUS_IGNORED : adcmv_pkg::STATUS_ABSORBED;
      end else begin
        res_status <= is_calibrated ? adcmv_pkg::STATUS_CONVERTED : adcmv_pkg::STATUS_NOT_CAL;
      end
    end
    if (state == adcmv_pkg::S_MUL) begin
      mul_hi  <= mul_sum[16:1];
      mul_lo  <= {mul_sum[0], mul_lo[15:1]};
      mul_cnt <= mul_cnt + 1'b1;
    end
    if (state == adcmv_pkg::S_DIV_MEAS && div_rsp.done) begin
      res_mv     <= div_rsp.quotient;
      res_status <= adcmv_pkg::STATUS_CONVERTED;
    end
    if (state == adcmv_pkg::S_DIV_SUPPLY && div_rsp.done) begin
      res_mv     <= div_rsp.quotient;
      res_status <= adcmv_pkg::STATUS_CAL_DONE;
    end
    if (out_load) begin
      millivolts <= res_mv;
      status     <= res_status;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/adcmv_checker.sv -----
// ----------------------------------------------------------------------------
// adcmv_checker
// port-level checks of the adc millivolt unit, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "adc_millivolt_with_vref_calibration_unit_assert.svh"

module adcmv_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] millivolts,
  input wire logic [2:0]  status
);

  logic has_value;

  // result codes that carry a millivolt value
  assign has_value = (status == adcmv_pkg::STATUS_CONVERTED) ||
                     (status == adcmv_pkg::STATUS_CAL_DONE);

  // only the five defined result codes leave the block
  `ADCMV_ASSERT_NOW(a_status_code, clk, rst, out_valid, status <= adcmv_pkg::STATUS_IGNORED)

  // results without a value carry zero millivolts
  `ADCMV_ASSERT_NOW(a_zero_mv, clk, rst, out_valid && !has_value, millivolts == 16'd0)

  // one item at a time: busy right after an accepted beat
  `ADCMV_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)

  // a stalled result beat holds
  `ADCMV_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(millivolts) && $stable(status))

endmodule

bind adc_millivolt_with_vref_calibration_unit adcmv_checker u_adcmv_checker (.*);

`default_nettype wire

// ----- verif/adc_millivolt_with_vref_calibration_unit_tb.sv -----
// ----------------------------------------------------------------------------
// adc_millivolt_with_vref_calibration_unit_tb
// Tests measurements refused before calibration, the one-time supply
// calibration from reference beats, and the millivolt scaling of measurements
// for both converter widths. Reference beats sent after calibration must be
// ignored. A model inside the bench predicts every result beat, and the
// checker compares the results in order. The sender and the receiver both
// stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module adc_millivolt_with_vref_calibration_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAL_SAMPLES   = 16;
  localparam int unsigned MEAS_ITEMS    = 570;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 50;

  typedef struct {
    logic [15:0]        mv;
    adcmv_pkg::status_t st;
  } reading_t;

  typedef enum int {
    CAL_TYPICAL,
    CAL_ZERO_AVG,
    CAL_TINY_AVG,
    CAL_LOW_AVG,
    CAL_SUM_SAT
  } cal_flavor_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        op = adcmv_pkg::OP_REF;
  logic [15:0] raw_sample = '0;
  logic        converter_kind = adcmv_pkg::KIND_16;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] millivolts;
  logic [2:0]  status;

  // model state of the calibration logic
  logic [15:0] ref_total;
  int unsigned refs_seen;
  logic [15:0] supply;
  logic        calibrated;

  reading_t pending_readings[$];
  int unsigned mismatches;

  // sender burst control and receiver stall pattern
  bit          tx_steady;
  bit          rx_steady;
  int unsigned burst_left;
  bit          rx_level;
  int unsigned rx_run_left;

  adc_millivolt_with_vref_calibration_unit #(
    .CAL_SAMPLES(CAL_SAMPLES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .op(op),
    .raw_sample(raw_sample),
    .converter_kind(converter_kind),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .millivolts(millivolts),
    .status(status)
  );

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  // expected result of one accepted input beat, advances the model state
  function automatic reading_t predict_reading(input logic smp_op,
                                               input logic [15:0] smp_raw,
                                               input logic smp_kind);
    reading_t    res;
    logic [16:0] wide_sum;
    logic [15:0] avg;
    logic [31:0] quot;
    logic [31:0] prod;
    logic [31:0] full_scale;
    res.mv = '0;
    res.st = adcmv_pkg::STATUS_CONVERTED;
    if (smp_op == adcmv_pkg::OP_REF) begin
      if (calibrated) begin
        res.st = adcmv_pkg::STATUS_IGNORED;
      end else begin
        // saturating running sum
        wide_sum = {1'b0, ref_total} + {1'b0, smp_raw};
        ref_total = (wide_sum > {1'b0, adcmv_pkg::MAX16}) ? adcmv_pkg::MAX16 : wide_sum[15:0];
        refs_seen++;
        if (refs_seen >= CAL_SAMPLES) begin
          avg = 16'(ref_total / 16'(CAL_SAMPLES));
          if (avg == '0) begin
            supply = adcmv_pkg::MAX16;
          end else begin
            quot = adcmv_pkg::VREF_PRODUCT / {16'd0, avg};
            supply = (quot > {16'd0, adcmv_pkg::MAX16}) ? adcmv_pkg::MAX16 : quot[15:0];
          end
          calibrated = 1'b1;
          res.mv = supply;
          res.st = adcmv_pkg::STATUS_CAL_DONE;
        end else begin
          res.st = adcmv_pkg::STATUS_ABSORBED;
        end
      end
    end else if (!calibrated) begin
      res.st = adcmv_pkg::STATUS_NOT_CAL;
    end else begin
      // scale by supply over full scale, saturate to 16 bits
      full_scale = (smp_kind == adcmv_pkg::KIND_12) ? {16'd0, adcmv_pkg::FS12}
                                                    : {16'd0, adcmv_pkg::FS16};
      prod = {16'd0, smp_raw} * {16'd0, supply};
      quot = prod / full_scale;
      res.mv = (quot > {16'd0, adcmv_pkg::MAX16}) ? adcmv_pkg::MAX16 : quot[15:0];
      res.st = adcmv_pkg::STATUS_CONVERTED;
    end
    return res;
  endfunction

  // result checker and input monitor, sampled at the rising edge
  always @(posedge clk) begin
    reading_t exp_rd;
    if (rst) begin
      ref_total  = '0;
      refs_seen  = 0;
      supply     = '0;
      calibrated = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_readings.size() == 0) begin
          $error("result beat with nothing expected: millivolts %0d status %0d",
                 millivolts, status);
          mismatches++;
        end else begin
          exp_rd = pending_readings.pop_front();
          if (millivolts !== exp_rd.mv) begin
            $error("millivolts: expected %0d, actual %0d", exp_rd.mv, millivolts);
            mismatches++;
          end
          if (status !== exp_rd.st) begin
            $error("status: expected %0d, actual %0d", exp_rd.st, status);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        pending_readings.push_back(predict_reading(op, raw_sample, converter_kind));
      end
    end
  end

  // receiver: alternating ready and stall runs unless held steady
  always @(negedge clk) begin
    if (rx_steady) begin
      out_ready <= 1'b1;
    end else begin
      if (rx_run_left == 0) begin
        rx_level = ~rx_level;
        rx_run_left = rx_level ? $urandom_range(1, 20) : $urandom_range(1, 40);
      end
      rx_run_left--;
      out_ready <= rx_level;
    end
  end

  // send one input beat, at the start of a burst with a random gap, possibly none, in front of it
  task automatic send_sample(input logic smp_op, input logic [15:0] smp_raw,
                             input logic smp_kind);
    int unsigned gap;
    gap = 0;
    if (!tx_steady) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      end
      burst_left--;
    end
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    op             <= smp_op;
    raw_sample     <= smp_raw;
    converter_kind <= smp_kind;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  // hold the sender off until every expected result has come back
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_raw();
    logic [15:0] val;
    case ($urandom_range(0, 5))
      0: val = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      1: val = 16'($urandom_range(0, 4095));
      default: val = 16'($urandom_range(0, 65535));
    endcase
    return val;
  endfunction

  // measurements before calibration are refused
  task automatic test_uncalibrated_measurements();
    send_sample(adcmv_pkg::OP_MEAS, 16'h0000, adcmv_pkg::KIND_16);
    send_sample(adcmv_pkg::OP_MEAS, 16'hFFFF, adcmv_pkg::KIND_12);
    send_sample(adcmv_pkg::OP_MEAS, 16'h5A5A, adcmv_pkg::KIND_16);
  endtask

  // one calibration per run; the flavor picks which corner it lands on
  task automatic test_calibration();
    cal_flavor_t flavor;
    logic [15:0] val;
    flavor = cal_flavor_t'($urandom_range(0, 4));
    for (int i = 0; i < CAL_SAMPLES; i++) begin
      case (flavor)
        CAL_ZERO_AVG: val = (i == 0) ? 16'd15 : 16'd0;
        CAL_TINY_AVG: val = 16'($urandom_range(1, 75));
        CAL_LOW_AVG:  val = 16'($urandom_range(100, 1200));
        CAL_SUM_SAT:  val = (i == 0) ? 16'hFFFF : 16'($urandom_range(0, 65535));
        default:      val = (i == 1) ? 16'd4095 : 16'($urandom_range(1400, 1700));
      endcase
      send_sample(adcmv_pkg::OP_REF, val, 1'($urandom_range(0, 1)));
    end
    wait_drained();
  endtask

  // extremes of the measurement range for both converter widths
  task automatic test_measure_extremes();
    send_sample(adcmv_pkg::OP_MEAS, 16'h0000, adcmv_pkg::KIND_16);
    send_sample(adcmv_pkg::OP_MEAS, 16'hFFFF, adcmv_pkg::KIND_16);
    send_sample(adcmv_pkg::OP_MEAS, 16'hFFFF, adcmv_pkg::KIND_12);
    send_sample(adcmv_pkg::OP_MEAS, 16'h0001, adcmv_pkg::KIND_12);
  endtask

  // reference beats after calibration are ignored
  task automatic test_ignored_refs();
    send_sample(adcmv_pkg::OP_REF, 16'h0000, adcmv_pkg::KIND_16);
    send_sample(adcmv_pkg::OP_REF, 16'hFFFF, adcmv_pkg::KIND_12);
  endtask

  // random measurements with some stray reference beats, in four phases of steady or stalling sender and receiver
  task automatic test_random_traffic();
    int unsigned done_meas;
    int unsigned per_phase;
    per_phase = MEAS_ITEMS / 4;
    done_meas = 0;
    for (int phase = 0; phase < 4; phase++) begin
      tx_steady = (phase == 1) || (phase == 3);
      rx_steady = (phase == 1) || (phase == 2);
      while (done_meas < per_phase * (phase + 1)) begin
        if ($urandom_range(0, 11) == 0) begin
          send_sample(adcmv_pkg::OP_REF, pick_raw(), 1'($urandom_range(0, 1)));
        end else begin
          send_sample(adcmv_pkg::OP_MEAS, pick_raw(), 1'($urandom_range(0, 1)));
          done_meas++;
        end
      end
      wait_drained();
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // test sequence
  initial begin
    mismatches  = 0;
    tx_steady   = 1'b0;
    rx_steady   = 1'b0;
    burst_left  = 0;
    rx_level    = 1'b0;
    rx_run_left = 0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    test_uncalibrated_measurements();
    test_calibration();
    test_measure_extremes();
    test_ignored_refs();
    test_random_traffic();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_readings.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
